// ----- rtl/psq_pkg.sv -----
// ----------------------------------------------------------------------------
// psq_pkg
// shared widths, register indexes, limits and types of the peak scorer
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

    localparam int LEVEL_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int POS_W      = 32;
    localparam int AREA_W     = 48;
    localparam int DAREA_W    = AREA_W + 1;
    localparam int SEG_AREA_W = 47;
    localparam int SEG_RNG_W  = 24;
    localparam int SLOPE_W    = 32;
    localparam int FILL_W     = 16;
    localparam int QUAL_W     = 24;
    localparam int SLVL_W     = 24;
    localparam int SRNG_W     = 24;
    localparam int SSLP_W     = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int NET_W      = 66;
    localparam int DIV_W      = 64;
    localparam int DIVQ_W     = 32;
    localparam int DIVC_W     = 6;
    localparam int TERM_R_W   = 20;
    localparam int TERM_N     = 5;
    localparam int TERM_IX_W  = 3;
    localparam int TERM_N_W   = 33;
    localparam int TERM_D_W   = 32;
    localparam int SUM_W      = QUAL_W + 3;

    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_TDATA_W = 208;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LEVEL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LEFT_RANGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RIGHT_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LEFT_SLOPE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RIGHT_SLOPE = 3'd4;

    localparam logic [SLVL_W-1:0] RST_SCALE_LEVEL = 24'hFFFF00;
    localparam logic [SRNG_W-1:0] RST_SCALE_RANGE = 24'd256;
    localparam logic [SSLP_W-1:0] RST_SCALE_SLOPE = 32'd65536;

    localparam logic [QUAL_W-1:0]     QUAL_SAT     = 24'hFFFFFF;
    localparam logic [SEG_AREA_W-1:0] AREA_SAT     = 47'h7FFF_FFFF_FFFF;
    localparam logic [SLOPE_W-1:0]    SLOPE_SAT    = 32'hFFFF_FFFF;
    localparam logic [FILL_W-1:0]     FILL_SAT     = 16'hFFFF;
    localparam logic [QUAL_W-1:0]     GREAT_PEAK   = 24'd19660;
    localparam logic [QUAL_W-1:0]     GREAT_SHAPE  = 24'd13107;
    localparam logic [QUAL_W-1:0]     GOOD_SHAPE   = 24'd32768;
    localparam logic [QUAL_W-1:0]     ACCEPT_SHAPE = 24'd49152;

    localparam logic [DIVC_W-1:0] SLOPE_QBITS = 6'd32;
    localparam logic [DIVC_W-1:0] FILL_QBITS  = 6'd16;
    localparam logic [DIVC_W-1:0] TERM_QBITS  = 6'd20;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_MUL,
        BS_AREA,
        BS_SLOPE,
        BS_SLOPE_W,
        BS_FILL,
        BS_FILL_W,
        BS_TERM,
        BS_TERM_W,
        BS_SQ,
        BS_SUM,
        BS_DONE
    } t_back_state;

    typedef struct packed {
        logic              start;
        logic [DIVC_W-1:0] qbits;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- rtl/psq_div.sv -----
// ----------------------------------------------------------------------------
// psq_div
// restoring divider, one quotient bit per cycle, saturation check up front
// ----------------------------------------------------------------------------
`default_nettype none

module psq_div import psq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_req          i_req,
    input  wire logic [DIV_W-1:0]  i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output t_div_rsp               o_rsp,
    output logic [DIVQ_W-1:0]      o_quot
);

    localparam int SD_W = DIV_W + DIVQ_W;

    logic              r_busy;
    logic              r_done;
    logic              r_sat;
    logic [DIV_W-1:0]  r_rem;
    logic [SD_W-1:0]   r_sd;
    logic [DIVC_W-1:0] r_cnt;
    logic [DIVQ_W-1:0] r_quot;

    logic [SD_W-1:0] w_lim;
    logic            w_ge;

    assign w_lim = SD_W'(i_divisor) << i_req.qbits;
    assign w_ge  = SD_W'(r_rem) >= r_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_sat <= SD_W'(i_dividend) >= w_lim;
                if (SD_W'(i_dividend) >= w_lim) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt == DIVC_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_dividend;
            r_sd   <= w_lim >> 1;
            r_cnt  <= i_req.qbits;
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_sd[DIV_W-1:0];
            end
            r_quot <= {r_quot[DIVQ_W-2:0], w_ge};
            r_sd   <= r_sd >> 1;
            r_cnt  <= r_cnt - DIVC_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_quot     = r_quot;

endmodule

`default_nettype wire

// ----- rtl/psq_fifo.sv -----
// ----------------------------------------------------------------------------
// psq_fifo
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module psq_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rptr];

endmodule

`default_nettype wire

// ----- rtl/psq_front.sv -----
// ----------------------------------------------------------------------------
// psq_front
// takes peaks, links each to its predecessor and queues the segment basics
// ----------------------------------------------------------------------------
`default_nettype none

module psq_front import psq_pkg::*; #(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [POS_W-1:0]             i_position,
    input  wire logic signed [LEVEL_BITS-1:0] i_level,
    input  wire logic signed [AREA_W-1:0]     i_area_sum,
    input  wire logic                         i_is_max,
    input  wire logic                         i_trace_start,
    input  wire logic                         i_full,
    output logic                              o_push,
    output logic [2+POS_W+3*LEVEL_BITS+DAREA_W-1:0] o_item
);

    logic                         r_have_prior;
    logic [POS_W-1:0]             r_pos;
    logic signed [LEVEL_BITS-1:0] r_level;
    logic signed [AREA_W-1:0]     r_area;

    logic                         w_linked;
    logic                         w_cand;
    logic [POS_W-1:0]             w_len;
    logic signed [LEVEL_BITS:0]   w_diff;
    logic [LEVEL_BITS-1:0]        w_range;
    logic signed [LEVEL_BITS-1:0] w_lo;
    logic signed [DAREA_W-1:0]    w_darea;

    always_comb begin
        w_linked = r_have_prior && !i_trace_start;
        w_cand   = !i_is_max && i_level < 0;
        w_len    = w_linked ? i_position - r_pos : i_position;
        w_diff   = (LEVEL_BITS+1)'(i_level) - (LEVEL_BITS+1)'(r_level);
        w_range  = w_diff < 0 ? LEVEL_BITS'(-w_diff) : LEVEL_BITS'(w_diff);
        w_lo     = i_level < r_level ? i_level : r_level;
        w_darea  = DAREA_W'(i_area_sum) - DAREA_W'(r_area);
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_item  = {w_linked, w_cand, w_len, w_range, w_lo, r_level, w_darea};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prior <= 1'b0;
            r_pos        <= '0;
            r_level      <= '0;
            r_area       <= '0;
        end else if (o_push) begin
            r_have_prior <= 1'b1;
            r_pos        <= i_position;
            r_level      <= i_level;
            r_area       <= i_area_sum;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psq_back.sv -----
// ----------------------------------------------------------------------------
// psq_back
// sequencer that measures area, slope and fill and scores the prior peak
// ----------------------------------------------------------------------------
`default_nettype none

module psq_back import psq_pkg::*; #(
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic                   i_item_valid,
    input  wire logic [2+POS_W+3*LEVEL_BITS+DAREA_W-1:0] i_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [OUT_TDATA_W-1:0]      o_data,
    output logic [OUT_TUSER_W-1:0]      o_user
);

    localparam int LB   = LEVEL_BITS;
    localparam int P_W  = POS_W + 1 + LB;
    localparam int RL_W = LB + POS_W;
    localparam int CW   = (LB > SRNG_W) ? LB : SRNG_W;
    localparam int LV_W = TERM_N_W + 1;
    localparam int O_PL = DAREA_W;
    localparam int O_LO = O_PL + LB;
    localparam int O_RG = O_LO + LB;
    localparam int O_LN = O_RG + LB;
    localparam int O_CD = O_LN + POS_W;
    localparam int O_LK = O_CD + 1;

    t_back_state r_state;
    t_back_state n_state;

    logic [SLVL_W-1:0] r_slvl;
    logic [SRNG_W-1:0] r_slr;
    logic [SRNG_W-1:0] r_srr;
    logic [SSLP_W-1:0] r_sls;
    logic [SSLP_W-1:0] r_srs;

    logic                  r_linked;
    logic                  r_cand;
    logic [POS_W-1:0]      r_len;
    logic [LB-1:0]         r_range;
    logic signed [LB-1:0]  r_lo;
    logic signed [LB-1:0]  r_pl;
    logic signed [DAREA_W-1:0] r_darea;
    logic signed [P_W-1:0] r_prod;
    logic [SEG_AREA_W-1:0] r_area;
    logic [RL_W-1:0]       r_rl;
    logic [SLOPE_W-1:0]    r_slope;
    logic [FILL_W-1:0]     r_fill;
    logic [TERM_IX_W-1:0]  r_tix;
    logic [TERM_R_W-1:0]   r_r;
    logic [QUAL_W-1:0]     r_term [TERM_N];
    logic [QUAL_W-1:0]     r_qp;
    logic [QUAL_W-1:0]     r_qs;
    logic [LB-1:0]         r_plr;
    logic [SLOPE_W-1:0]    r_pls;

    logic                   r_mvalid;
    logic [OUT_TDATA_W-1:0] r_mdata;
    logic [OUT_TUSER_W-1:0] r_muser;

    t_div_req          w_req;
    t_div_rsp          w_rsp;
    logic [DIV_W-1:0]  w_dividend;
    logic [DIV_W-1:0]  w_divisor;
    logic [DIVQ_W-1:0] w_quot;

    logic signed [NET_W-1:0] w_prodc;
    logic signed [NET_W-1:0] w_net;
    logic [NET_W-1:0]        w_abs;
    logic [SEG_AREA_W-1:0]   w_area;
    logic [RL_W-1:0]         w_rl;

    logic signed [LV_W-1:0] w_pl_x;
    logic signed [LV_W-1:0] w_sl_x;
    logic signed [LV_W-1:0] w_sl_abs;
    logic [TERM_N_W-1:0]    w_n;
    logic [TERM_D_W-1:0]    w_d;
    logic                   w_last;
    logic                   w_out_free;
    logic [2*TERM_R_W-1:0]  w_sq;
    logic                   w_sh_lr;
    logic                   w_sh_rr;
    logic                   w_sh_ls;
    logic                   w_sh_rs;
    logic [SUM_W-1:0]       w_qp_sum;
    logic [SUM_W-1:0]       w_qs_sum;
    logic [QUAL_W-1:0]      w_qp;
    logic [QUAL_W-1:0]      w_qs;
    logic [OUT_TDATA_W-1:0] w_mdata;

    psq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_rsp      (w_rsp),
        .o_quot     (w_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slvl <= RST_SCALE_LEVEL;
            r_slr  <= RST_SCALE_RANGE;
            r_srr  <= RST_SCALE_RANGE;
            r_sls  <= RST_SCALE_SLOPE;
            r_srs  <= RST_SCALE_SLOPE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE_LEVEL:       r_slvl <= i_cfg_data[SLVL_W-1:0];
                CFG_SCALE_LEFT_RANGE:  r_slr  <= i_cfg_data[SRNG_W-1:0];
                CFG_SCALE_RIGHT_RANGE: r_srr  <= i_cfg_data[SRNG_W-1:0];
                CFG_SCALE_LEFT_SLOPE:  r_sls  <= i_cfg_data[SSLP_W-1:0];
                CFG_SCALE_RIGHT_SLOPE: r_srs  <= i_cfg_data[SSLP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // segment area and divisor product
    always_comb begin
        w_prodc = NET_W'(r_prod);
        if (w_prodc > (NET_W'(1) <<< 60)) begin
            w_prodc = NET_W'(1) <<< 60;
        end else if (w_prodc < -(NET_W'(1) <<< 60)) begin
            w_prodc = -(NET_W'(1) <<< 60);
        end
        w_net  = NET_W'(r_darea) - w_prodc;
        w_abs  = w_net < 0 ? NET_W'(-w_net) : NET_W'(w_net);
        w_area = w_abs > NET_W'(AREA_SAT) ? AREA_SAT : w_abs[SEG_AREA_W-1:0];
        w_rl   = RL_W'(r_range) * RL_W'(r_len);
    end

    // deviation term operands
    always_comb begin
        w_pl_x   = LV_W'(r_pl);
        w_sl_x   = LV_W'($signed(r_slvl));
        w_sl_abs = w_sl_x < 0 ? -w_sl_x : w_sl_x;
        w_n      = '0;
        w_d      = '0;
        case (r_tix)
            3'd0: begin
                w_d = TERM_D_W'(w_sl_abs);
                if (w_pl_x > w_sl_x) begin
                    w_n = TERM_N_W'(w_pl_x - w_sl_x);
                end
            end
            3'd1: begin
                w_d = TERM_D_W'(r_slr);
                if (CW'(r_plr) < CW'(r_slr)) begin
                    w_n = TERM_N_W'(CW'(r_slr) - CW'(r_plr));
                end
            end
            3'd2: begin
                w_d = TERM_D_W'(r_srr);
                if (CW'(r_range) < CW'(r_srr)) begin
                    w_n = TERM_N_W'(CW'(r_srr) - CW'(r_range));
                end
            end
            3'd3: begin
                w_d = r_sls;
                w_n = TERM_N_W'(r_pls > r_sls ? r_pls - r_sls : r_sls - r_pls);
            end
            3'd4: begin
                w_d = r_srs;
                w_n = TERM_N_W'(r_slope > r_srs ? r_slope - r_srs : r_srs - r_slope);
            end
            default: begin
            end
        endcase
        w_last = r_tix == TERM_IX_W'(TERM_N - 1);
        w_sq   = r_r * r_r;
    end

    // quality sums and flags
    always_comb begin
        w_sh_lr  = (CW+1)'(r_plr) * 2 < (CW+1)'(r_slr);
        w_sh_rr  = (CW+1)'(r_range) * 2 < (CW+1)'(r_srr);
        w_sh_ls  = r_pls < r_sls;
        w_sh_rs  = r_slope < r_srs;
        w_qp_sum = SUM_W'(r_term[0]) + SUM_W'(r_term[1]) + SUM_W'(r_term[2])
                 + SUM_W'(r_term[3]) + SUM_W'(r_term[4]);
        w_qs_sum = (w_sh_lr ? SUM_W'(r_term[1]) : '0) + (w_sh_rr ? SUM_W'(r_term[2]) : '0)
                 + (w_sh_ls ? SUM_W'(r_term[3]) : '0) + (w_sh_rs ? SUM_W'(r_term[4]) : '0);
        w_qp     = w_qp_sum > SUM_W'(QUAL_SAT) ? QUAL_SAT : w_qp_sum[QUAL_W-1:0];
        w_qs     = w_qs_sum > SUM_W'(QUAL_SAT) ? QUAL_SAT : w_qs_sum[QUAL_W-1:0];
    end

    assign w_out_free = !r_mvalid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_item_valid) begin
                    n_state = i_item[O_LK] ? BS_MUL : BS_DONE;
                end
            end
            BS_MUL:  n_state = BS_AREA;
            BS_AREA: n_state = BS_SLOPE;
            BS_SLOPE: begin
                n_state = (r_len != '0) ? BS_SLOPE_W : BS_FILL;
            end
            BS_SLOPE_W: begin
                if (w_rsp.done) begin
                    n_state = BS_FILL;
                end
            end
            BS_FILL: begin
                n_state = (r_len != '0 && r_range != '0) ? BS_FILL_W : BS_TERM;
            end
            BS_FILL_W: begin
                if (w_rsp.done) begin
                    n_state = BS_TERM;
                end
            end
            BS_TERM: begin
                if (w_d != '0) begin
                    n_state = BS_TERM_W;
                end else if (w_last) begin
                    n_state = BS_SUM;
                end
            end
            BS_TERM_W: begin
                if (w_rsp.done) begin
                    if (!w_rsp.sat) begin
                        n_state = BS_SQ;
                    end else begin
                        n_state = w_last ? BS_SUM : BS_TERM;
                    end
                end
            end
            BS_SQ:   n_state = w_last ? BS_SUM : BS_TERM;
            BS_SUM:  n_state = BS_DONE;
            BS_DONE: begin
                if (w_out_free) begin
                    n_state = BS_IDLE;
                end
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_pop       = 1'b0;
        w_req.start = 1'b0;
        w_req.qbits = TERM_QBITS;
        w_dividend  = DIV_W'(w_n) << 16;
        w_divisor   = DIV_W'(w_d);
        unique case (r_state)
            BS_IDLE: o_pop = i_item_valid;
            BS_SLOPE: begin
                w_req.start = r_len != '0;
                w_req.qbits = SLOPE_QBITS;
                w_dividend  = DIV_W'(r_range) << (16 - FRACTION_BITS);
                w_divisor   = DIV_W'(r_len);
            end
            BS_FILL: begin
                w_req.start = r_len != '0 && r_range != '0;
                w_req.qbits = FILL_QBITS;
                w_dividend  = DIV_W'(r_area) << 15;
                w_divisor   = DIV_W'(r_rl);
            end
            BS_TERM: w_req.start = w_d != '0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BS_IDLE: begin
                r_linked <= i_item[O_LK];
                r_cand   <= i_item[O_CD];
                r_len    <= i_item[O_CD-1:O_LN];
                r_range  <= i_item[O_LK] ? i_item[O_LN-1:O_RG] : '0;
                r_lo     <= i_item[O_RG-1:O_LO];
                r_pl     <= i_item[O_LO-1:O_PL];
                r_darea  <= i_item[DAREA_W-1:0];
                r_area   <= '0;
                r_slope  <= '0;
                r_fill   <= '0;
                r_qp     <= '0;
                r_qs     <= '0;
                r_tix    <= '0;
            end
            BS_MUL: r_prod <= $signed({1'b0, r_len}) * r_lo;
            BS_AREA: begin
                r_area <= w_area;
                r_rl   <= w_rl;
            end
            BS_SLOPE_W: begin
                if (w_rsp.done) begin
                    r_slope <= w_rsp.sat ? SLOPE_SAT : w_quot;
                end
            end
            BS_FILL_W: begin
                if (w_rsp.done) begin
                    r_fill <= w_rsp.sat ? FILL_SAT : w_quot[FILL_W-1:0];
                end
            end
            BS_TERM: begin
                if (w_d == '0) begin
                    r_term[r_tix] <= (w_n != '0) ? QUAL_SAT : '0;
                    r_tix         <= r_tix + TERM_IX_W'(1);
                end
            end
            BS_TERM_W: begin
                if (w_rsp.done) begin
                    r_r <= w_quot[TERM_R_W-1:0];
                    if (w_rsp.sat) begin
                        r_term[r_tix] <= QUAL_SAT;
                        r_tix         <= r_tix + TERM_IX_W'(1);
                    end
                end
            end
            BS_SQ: begin
                r_term[r_tix] <= w_sq[2*TERM_R_W-1:16];
                r_tix         <= r_tix + TERM_IX_W'(1);
            end
            BS_SUM: begin
                r_qp <= w_qp;
                r_qs <= w_qs;
            end
            BS_DONE: begin
                if (w_out_free) begin
                    r_plr <= r_range;
                    r_pls <= r_slope;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_mdata = {
            6'd0,
            r_linked && r_qs <= ACCEPT_SHAPE,
            r_linked && r_qs <= GOOD_SHAPE,
            r_linked && (r_qp <= GREAT_PEAK || r_qs <= GREAT_SHAPE),
            r_qs,
            r_qp,
            r_fill,
            r_slope,
            r_area,
            SEG_RNG_W'(r_range),
            r_len
        };
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (r_state == BS_DONE && w_out_free) begin
            r_mvalid <= 1'b1;
        end else if (i_ready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BS_DONE && w_out_free) begin
            r_mdata <= w_mdata;
            r_muser <= {r_linked, r_cand};
        end
    end

    assign o_valid = r_mvalid;
    assign o_data  = r_mdata;
    assign o_user  = r_muser;

endmodule

`default_nettype wire

// ----- rtl/peak_segment_quality_scorer.sv -----
// ----------------------------------------------------------------------------
// peak_segment_quality_scorer
// segment measures and prior-peak quality scores for a stream of peaks
// ----------------------------------------------------------------------------
// Each accepted peak gives one result: length, range, area, slope and fill of
// the segment back to the previous peak, and the quality of that previous
// peak against the scale registers. Back-end time per peak is set by one
// shared divider that yields one quotient bit a cycle (32 bits for slope, 16
// for fill, 20 for each of five deviation terms); the front end and a two-entry
// queue take up to two more peaks meanwhile, and the output register holds a
// finished result while the next one is computed. The user is to write scale
// registers only while no peak is in flight; the block does not enforce this.
`default_nettype none

module peak_segment_quality_scorer import psq_pkg::*; #(
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    // peak_position, peak_level, peak_area_sum, zero fill
    input  wire logic [((POS_W+LEVEL_BITS+AREA_W+7)/8)*8-1:0] i_s_tdata,
    // peak_is_max, trace_start
    input  wire logic [IN_TUSER_W-1:0]   i_s_tuser,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    // seg_length, seg_range, seg_area, seg_slope, seg_fill, prior_peak_quality,
    // prior_shape_quality, prior_great, prior_good, prior_acceptable, zero fill
    output logic [OUT_TDATA_W-1:0]       o_m_tdata,
    // candidate, prior_scored
    output logic [OUT_TUSER_W-1:0]       o_m_tuser
);

    localparam int ITEM_W = 2 + POS_W + 3*LEVEL_BITS + DAREA_W;

    logic              w_full;
    logic              w_push;
    logic [ITEM_W-1:0] w_item_in;
    logic              w_pop;
    logic              w_item_valid;
    logic [ITEM_W-1:0] w_item_out;

    psq_front #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_position    (i_s_tdata[POS_W-1:0]),
        .i_level       (i_s_tdata[POS_W+LEVEL_BITS-1:POS_W]),
        .i_area_sum    (i_s_tdata[POS_W+LEVEL_BITS+AREA_W-1:POS_W+LEVEL_BITS]),
        .i_is_max      (i_s_tuser[0]),
        .i_trace_start (i_s_tuser[1]),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_item_in)
    );

    psq_fifo #(
        .W (ITEM_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_item_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_item_valid),
        .o_data  (w_item_out)
    );

    psq_back #(
        .LEVEL_BITS    (LEVEL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_item_valid),
        .i_item       (w_item_out),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_data       (o_m_tdata),
        .o_user       (o_m_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/peak_segment_quality_scorer_tb.sv -----
// ----------------------------------------------------------------------------
// peak_segment_quality_scorer_tb
// self-checking bench: a queue-fed stream driver, an output monitor and an
// in-bench scorer that predicts every result, run over several scale settings
// with sender gaps, receiver stalls and a long output hold
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module peak_segment_quality_scorer_tb;
    import psq_pkg::*;

    localparam int IN_TDATA_W = ((POS_W + 24 + AREA_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [31:0] pos;
        logic [23:0] level;
        logic [47:0] area;
        logic        is_max;
        logic        tstart;
    } t_peak;

    typedef struct packed {
        logic [31:0] len;
        logic [23:0] rng;
        logic [46:0] area;
        logic [31:0] slope;
        logic [15:0] fill;
        logic        cand;
        logic        scored;
        logic [23:0] pq;
        logic [23:0] sq;
        logic        great;
        logic        good;
        logic        accept;
    } t_seg;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic [IN_TUSER_W-1:0]  s_user = '0;
    logic                   o_m_tvalid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;

    peak_segment_quality_scorer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    t_peak pending_peaks[$];
    t_seg  expected_segs[$];
    t_peak cur_peak;
    int    send_idle = 0;
    int    recv_stall = 0;
    int    hold_req = 0;
    int    hold_seen = 0;
    int    hold_cnt = 0;
    int    errors = 0;
    int    cycles = 0;

    // scorer copy of scale registers and prior-peak state
    logic [63:0] sc_level, sc_lrange, sc_rrange, sc_lslope, sc_rslope;
    logic        have_prior;
    logic [31:0] pr_pos;
    logic [23:0] pr_level;
    logic [47:0] pr_area;
    logic [63:0] pr_lrange, pr_lslope;

    // generator state for well-formed traces
    logic [31:0] g_pos;
    longint      g_level;
    longint      g_area;
    logic        g_max;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] dev_term(logic [63:0] n, logic [63:0] d);
        logic [63:0] r;
        if (d == 0) return (n != 0) ? 32'hFFFFFF : 32'd0;
        r = (n << 16) / d;
        if (r >= 64'h100000) return 32'hFFFFFF;
        return 32'((r * r) >> 16);
    endfunction

    function automatic logic [31:0] qadd(logic [31:0] a, logic [31:0] b);
        logic [31:0] s;
        s = a + b;
        return (s > 32'hFFFFFF) ? 32'hFFFFFF : s;
    endfunction

    function automatic t_seg score_peak(t_peak p);
        longint      lv, pl, ar, pa, lo, prod, net, sl;
        logic [31:0] len32, qp, qs;
        logic [63:0] len, rng, area, slope, fill, sl_abs, lr, lg;
        t_seg        r;
        lv = $signed(p.level);
        ar = $signed(p.area);
        rng = 0; area = 0; slope = 0; fill = 0; qp = 0; qs = 0;
        r = '{default: '0};
        if (!have_prior || p.tstart) begin
            len = {32'd0, p.pos};
        end else begin
            pl = $signed(pr_level);
            pa = $signed(pr_area);
            lo = (lv < pl) ? lv : pl;
            len32 = p.pos - pr_pos;
            len = {32'd0, len32};
            rng = (lv > pl) ? lv - pl : pl - lv;
            prod = $signed(len) * lo;
            if (prod > (64'sd1 <<< 60)) prod = 64'sd1 <<< 60;
            if (prod < -(64'sd1 <<< 60)) prod = -(64'sd1 <<< 60);
            net = (ar - pa) - prod;
            area = (net < 0) ? -net : net;
            if (area > 64'h7FFF_FFFF_FFFF) area = 64'h7FFF_FFFF_FFFF;
            if (len != 0) begin
                slope = (rng << 8) / len;
                if (slope > 64'hFFFF_FFFF) slope = 64'hFFFF_FFFF;
                if (rng != 0) begin
                    fill = (area << 15) / (rng * len);
                    if (fill > 64'hFFFF) fill = 64'hFFFF;
                end
            end
            sl = $signed(sc_level[23:0]);
            sl_abs = (sl < 0) ? -sl : sl;
            lr = pr_lrange;
            lg = pr_lslope;
            if (pl > sl) qp = qadd(qp, dev_term(pl - sl, sl_abs));
            if (lr < sc_lrange) qp = qadd(qp, dev_term(sc_lrange - lr, sc_lrange));
            if (rng < sc_rrange) qp = qadd(qp, dev_term(sc_rrange - rng, sc_rrange));
            qp = qadd(qp, dev_term((lg > sc_lslope) ? lg - sc_lslope : sc_lslope - lg,
                                   sc_lslope));
            qp = qadd(qp, dev_term((slope > sc_rslope) ? slope - sc_rslope
                                   : sc_rslope - slope, sc_rslope));
            if (2 * lr < sc_lrange) qs = qadd(qs, dev_term(sc_lrange - lr, sc_lrange));
            if (2 * rng < sc_rrange) qs = qadd(qs, dev_term(sc_rrange - rng, sc_rrange));
            if (lg < sc_lslope) qs = qadd(qs, dev_term(sc_lslope - lg, sc_lslope));
            if (slope < sc_rslope) qs = qadd(qs, dev_term(sc_rslope - slope, sc_rslope));
            r.scored = 1'b1;
            r.pq = qp[23:0];
            r.sq = qs[23:0];
            r.great = (qp <= GREAT_PEAK) || (qs <= GREAT_SHAPE);
            r.good = qs <= GOOD_SHAPE;
            r.accept = qs <= ACCEPT_SHAPE;
        end
        r.len = len[31:0];
        r.rng = rng[23:0];
        r.area = area[46:0];
        r.slope = slope[31:0];
        r.fill = fill[15:0];
        r.cand = !p.is_max && (lv < 0);
        have_prior = 1'b1;
        pr_pos = p.pos;
        pr_level = p.level;
        pr_area = p.area;
        pr_lrange = rng;
        pr_lslope = slope;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_peak nxt;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready) expected_segs.push_back(score_peak(cur_peak));
            if (!s_valid || o_s_tready) begin
                if (pending_peaks.size() > 0 && $urandom_range(99) >= send_idle) begin
                    nxt = pending_peaks.pop_front();
                    cur_peak = nxt;
                    s_data <= {nxt.area, nxt.level, nxt.pos};
                    s_user <= {nxt.tstart, nxt.is_max};
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with long holds on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt <= 3000;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_stall;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_seg e, a;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            a.len = o_m_tdata[31:0];
            a.rng = o_m_tdata[55:32];
            a.area = o_m_tdata[102:56];
            a.slope = o_m_tdata[134:103];
            a.fill = o_m_tdata[150:135];
            a.pq = o_m_tdata[174:151];
            a.sq = o_m_tdata[198:175];
            a.great = o_m_tdata[199];
            a.good = o_m_tdata[200];
            a.accept = o_m_tdata[201];
            a.cand = o_m_tuser[0];
            a.scored = o_m_tuser[1];
            if (expected_segs.size() == 0) begin
                $display("%t unexpected transfer %h %h", $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                e = expected_segs.pop_front();
                if (a.len != e.len)
                    $display("%t seg_length exp %h got %h", $time, e.len, a.len);
                if (a.rng != e.rng)
                    $display("%t seg_range exp %h got %h", $time, e.rng, a.rng);
                if (a.area != e.area)
                    $display("%t seg_area exp %h got %h", $time, e.area, a.area);
                if (a.slope != e.slope)
                    $display("%t seg_slope exp %h got %h", $time, e.slope, a.slope);
                if (a.fill != e.fill)
                    $display("%t seg_fill exp %h got %h", $time, e.fill, a.fill);
                if (a.cand != e.cand)
                    $display("%t candidate exp %b got %b", $time, e.cand, a.cand);
                if (a.scored != e.scored)
                    $display("%t prior_scored exp %b got %b", $time, e.scored, a.scored);
                if (a.pq != e.pq)
                    $display("%t peak_quality exp %h got %h", $time, e.pq, a.pq);
                if (a.sq != e.sq)
                    $display("%t shape_quality exp %h got %h", $time, e.sq, a.sq);
                if ({a.great, a.good, a.accept} != {e.great, e.good, e.accept})
                    $display("%t great/good/acceptable exp %b%b%b got %b%b%b", $time,
                             e.great, e.good, e.accept, a.great, a.good, a.accept);
                if (a != e) errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[peak_segment_quality_scorer] ERROR");
            $finish;
        end
    end

    task automatic set_scales(logic [31:0] lvl, logic [31:0] lr, logic [31:0] rr,
                              logic [31:0] ls, logic [31:0] rs);
        logic [31:0] vals[5];
        vals = '{lvl, lr, rr, ls, rs};
        for (int k = 0; k < 5; k++) begin
            @(posedge i_clk);
            cfg_we <= 1'b1;
            cfg_idx <= CFG_IDX_W'(k);
            cfg_data <= vals[k];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sc_level = {40'd0, lvl[23:0]};
        sc_lrange = {40'd0, lr[23:0]};
        sc_rrange = {40'd0, rr[23:0]};
        sc_lslope = {32'd0, ls};
        sc_rslope = {32'd0, rs};
    endtask

    task automatic drain();
        while (pending_peaks.size() != 0 || s_valid || expected_segs.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_peak(logic [31:0] pos, logic [23:0] lvl, logic [47:0] ar,
                            logic mx, logic ts);
        pending_peaks.push_back('{pos, lvl, ar, mx, ts});
    endtask

    task automatic add_random_peak();
        longint step, rng;
        if ($urandom_range(9) < 8) begin
            step = $urandom_range(1, 8);
            rng = step * 256 * $urandom_range(20, 180) / 100;
            if ($urandom_range(15) == 0) rng = 0;
            g_max = !g_max;
            g_level = g_max ? g_level + rng : g_level - rng;
            if (g_level > 8388607 || g_level < -8388608)
                g_level = -longint'($urandom_range(0, 2048));
            g_pos = g_pos + 32'(step);
            g_area = g_area + step * g_level;
            add_peak(g_pos, 24'(g_level), 48'(g_area), g_max, $urandom_range(30) == 0);
        end else begin
            add_peak($urandom, 24'($urandom), {16'($urandom), 32'($urandom)},
                     1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        logic [31:0] cl [5];
        sc_level = 64'hFFFF00;
        sc_lrange = 256;
        sc_rrange = 256;
        sc_lslope = 65536;
        sc_rslope = 65536;
        have_prior = 1'b0;
        pr_pos = '0; pr_level = '0; pr_area = '0; pr_lrange = '0; pr_lslope = '0;
        g_pos = 1000; g_level = -256; g_area = 0; g_max = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first peak, zero length, zero range, wrap, field extremes
        add_peak(100, -24'sd256, 0, 0, 0);
        add_peak(101, -24'sd512, -48'sd300, 0, 0);
        add_peak(102, 24'd0, 48'd10, 1, 0);
        add_peak(102, 24'd256, 48'd20, 1, 0);
        add_peak(105, 24'd256, 48'd900, 0, 0);
        add_peak(50, -24'sd100, 48'd5, 0, 0);
        add_peak(51, 24'h800000, 48'h8000_0000_0000, 0, 0);
        add_peak(52, 24'h7FFFFF, 48'h7FFF_FFFF_FFFF, 1, 0);
        add_peak(32'hFFFF_FFFF, 24'h800000, 48'h8000_0000_0000, 0, 0);
        add_peak(0, 24'h7FFFFF, 48'hFFFF_FFFF_FFFF, 1, 1);
        add_peak(1, 24'h000100, 48'h0, 0, 1);
        add_peak(3, 24'hFFFE00, 48'h1, 1, 0);
        add_peak(5, 24'hFFFF00, 48'h2, 0, 0);
        add_peak(7, 24'h000000, 48'h3, 1, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: cl = '{32'hFFFF00, 256, 256, 65536, 65536};
                1: cl = '{0, 0, 0, 0, 0};
                2: cl = '{32'h7FFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
                3: cl = '{32'h800000, 1, 1, 1, 1};
                default: cl = '{32'(-$urandom_range(64, 1024)), $urandom_range(64, 2048),
                                $urandom_range(64, 2048), $urandom_range(8192, 300000),
                                $urandom_range(8192, 300000)};
            endcase
            set_scales(cl[0], cl[1], cl[2], cl[3], cl[4]);
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 57; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 57; end
                default: begin send_idle = 11; recv_stall = 11; end
            endcase
            if (ph == 4) begin
                send_idle = 0;
                hold_req <= hold_req + 1;
            end
            repeat (120) add_random_peak();
            // sender pause until everything is back
            drain();
            repeat (120) add_random_peak();
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("[peak_segment_quality_scorer] OK");
        end else begin
            $display("[peak_segment_quality_scorer] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
